// ===== src/ugil_pkg.sv =====
// ugil_pkg: shared types and constants of the utf8 glyph index lookup block
// holds command codes, lead byte masks, bank codes and the
// controller/datapath interface structs
package ugil_pkg;

	// default table depths
	localparam int unsigned LEAD_DEPTH   = 64;
	localparam int unsigned MIDDLE_DEPTH = 256;
	localparam int unsigned GLYPH_DEPTH  = 4096;

	// field widths
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned LEAD3_COUNT_W = 9;
	localparam int unsigned NLEAD_W = 7;
	localparam int unsigned POS_W   = 12;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_LEAD2  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_LEAD3  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WR_MID3   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WR_LEAF2  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WR_LEAF3  = 3'd5;

	// configuration register indexes
	localparam logic CFG_LEAD2_ENTRIES = 1'b0;
	localparam logic CFG_LEAD3_ENTRIES = 1'b1;

	// lead byte classification
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;

	// glyph banks
	localparam logic [1:0] BANK_ONE   = 2'd0;
	localparam logic [1:0] BANK_TWO   = 2'd1;
	localparam logic [1:0] BANK_THREE = 2'd2;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ASCII,
		KIND_TWO,
		KIND_THREE
	} res_kind_t;

	// commands from controller to datapath
	typedef struct packed {
		logic      wr;
		logic      capture;
		logic      rd_lead2;
		logic      rd_leaf2;
		logic      rd_lead3;
		logic      rd_mid3;
		logic      rd_leaf3;
		logic      ld_cnt_lead2;
		logic      ld_cnt_lead3;
		logic      ld_cnt_mid;
		logic      add_skip_lead2;
		logic      add_skip_mid;
		logic      inc_i;
		logic      inc_skip_c;
		logic      inc_mid_c;
		logic      set_hit;
		logic      load_out;
		res_kind_t out_kind;
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic i_done2;
		logic i_done3;
		logic skip_over;
		logic mid_over;
		logic c_done;
		logic lead2_hit;
		logic leaf2_hit;
		logic mid_hit;
		logic leaf3_hit;
		logic is_ascii;
		logic is_two;
		logic is_three;
	} dp_status_t;

endpackage

// ===== src/utf8_glyph_index_lookup_top.sv =====
// utf8_glyph_index_lookup_top: a lookup beat stalls the input until its result is loaded into
// the output register; the stall grows with each lead, middle or leaf entry read, with each
// finished run the scan goes on from and with any stall at the output
// a table write beat is taken without a stall and the next beat can follow at once
// the result waits in an output register while the next beat is worked on
// reset clears state, output valid and entry count registers; tables are not
module utf8_glyph_index_lookup_top #(
	parameter int unsigned LEAD_DEPTH   = ugil_pkg::LEAD_DEPTH,
	parameter int unsigned MIDDLE_DEPTH = ugil_pkg::MIDDLE_DEPTH,
	parameter int unsigned GLYPH_DEPTH  = ugil_pkg::GLYPH_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ugil_pkg::CMD_W-1:0]   cmd,
	input  logic [ugil_pkg::INDEX_W-1:0] entry_index,
	input  logic [ugil_pkg::CODE_W-1:0]  entry_code,
	input  logic [ugil_pkg::COUNT_W-1:0] entry_count,
	input  logic [7:0]                   first_byte,
	input  logic [7:0]                   second_byte,
	input  logic [7:0]                   third_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [1:0]                   bytes_used,
	output logic [1:0]                   glyph_bank,
	output logic [ugil_pkg::POS_W-1:0]   glyph_position,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ugil_pkg::NLEAD_W-1:0] cfg_data
);

	ugil_pkg::ctl_cmd_t   ctl;
	ugil_pkg::dp_status_t st;

	// sequencer
	ugil_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_stall (out_stall),
		.st        (st),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.ctl       (ctl)
	);

	// tables, counters and result
	ugil_datapath #(
		.LEAD_DEPTH   (LEAD_DEPTH),
		.MIDDLE_DEPTH (MIDDLE_DEPTH),
		.GLYPH_DEPTH  (GLYPH_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.entry_index    (entry_index),
		.entry_code     (entry_code),
		.entry_count    (entry_count),
		.first_byte     (first_byte),
		.second_byte    (second_byte),
		.third_byte     (third_byte),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.ctl            (ctl),
		.st             (st),
		.found          (found),
		.bytes_used     (bytes_used),
		.glyph_bank     (glyph_bank),
		.glyph_position (glyph_position)
	);

endmodule

// ===== src/ugil_ram.sv =====
// ugil_ram: generic single write port, single read port ram
// registered read data; no dependencies
module ugil_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ugil_datapath.sv =====
// ugil_datapath: table memories, scan counters and result register
// depends on ugil_pkg and ugil_ram
module ugil_datapath #(
	parameter int unsigned LEAD_DEPTH   = ugil_pkg::LEAD_DEPTH,
	parameter int unsigned MIDDLE_DEPTH = ugil_pkg::MIDDLE_DEPTH,
	parameter int unsigned GLYPH_DEPTH  = ugil_pkg::GLYPH_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ugil_pkg::CMD_W-1:0]      cmd,
	input  logic [ugil_pkg::INDEX_W-1:0]    entry_index,
	input  logic [ugil_pkg::CODE_W-1:0]     entry_code,
	input  logic [ugil_pkg::COUNT_W-1:0]    entry_count,
	input  logic [7:0]                      first_byte,
	input  logic [7:0]                      second_byte,
	input  logic [7:0]                      third_byte,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [ugil_pkg::NLEAD_W-1:0]    cfg_data,
	input  ugil_pkg::ctl_cmd_t              ctl,
	output ugil_pkg::dp_status_t            st,
	output logic                            found,
	output logic [1:0]                      bytes_used,
	output logic [1:0]                      glyph_bank,
	output logic [ugil_pkg::POS_W-1:0]      glyph_position
);

	localparam int unsigned LAW = LEAD_DEPTH > 1 ? $clog2(LEAD_DEPTH) : 1;
	localparam int unsigned MAW = MIDDLE_DEPTH > 1 ? $clog2(MIDDLE_DEPTH) : 1;
	localparam int unsigned GAW = $clog2(GLYPH_DEPTH);
	localparam int unsigned IW  = $clog2(LEAD_DEPTH + 1);
	localparam int unsigned MW  = $clog2(MIDDLE_DEPTH + 1);
	localparam int unsigned SKW = (GAW > ugil_pkg::COUNT_W ? GAW : ugil_pkg::COUNT_W) + 1;
	localparam int unsigned CW  = ugil_pkg::CODE_W;
	localparam int unsigned NW  = ugil_pkg::COUNT_W;
	localparam int unsigned N3W = ugil_pkg::LEAD3_COUNT_W;

	logic [ugil_pkg::NLEAD_W-1:0] n2_q, n3_q;
	logic [7:0]    b0_q, b1_q, b2_q;
	logic [IW-1:0] i_q;
	logic [MW-1:0] mid_q;
	logic [SKW-1:0] skip_q;
	logic [NW-1:0] c_q, cnt_q;
	logic          hit_q;

	logic [31:0] idx32;
	logic we_lead2, we_lead3, we_mid3, we_leaf2, we_leaf3;
	logic [CW+NW-1:0]  lead2_rd, mid3_rd;
	logic [CW+N3W-1:0] lead3_rd;
	logic [CW-1:0]     leaf2_rd, leaf3_rd;

	// write decode, out of range indexes dropped
	always_comb begin
		idx32    = {20'd0, entry_index};
		we_lead2 = 1'b0;
		we_lead3 = 1'b0;
		we_mid3  = 1'b0;
		we_leaf2 = 1'b0;
		we_leaf3 = 1'b0;
		case (cmd)
			ugil_pkg::CMD_WR_LEAD2: we_lead2 = ctl.wr && (idx32 < 32'(LEAD_DEPTH));
			ugil_pkg::CMD_WR_LEAD3: we_lead3 = ctl.wr && (idx32 < 32'(LEAD_DEPTH));
			ugil_pkg::CMD_WR_MID3:  we_mid3  = ctl.wr && (idx32 < 32'(MIDDLE_DEPTH));
			ugil_pkg::CMD_WR_LEAF2: we_leaf2 = ctl.wr && (idx32 < 32'(GLYPH_DEPTH));
			ugil_pkg::CMD_WR_LEAF3: we_leaf3 = ctl.wr && (idx32 < 32'(GLYPH_DEPTH));
			default: ;
		endcase
	end

	// table memories
	ugil_ram #(.WIDTH(CW + NW), .DEPTH(LEAD_DEPTH)) u_lead2 (
		.clk(clk), .we(we_lead2), .waddr(idx32[LAW-1:0]),
		.wdata({entry_code, entry_count}),
		.re(ctl.rd_lead2), .raddr(i_q[LAW-1:0]), .rdata(lead2_rd)
	);

	ugil_ram #(.WIDTH(CW + N3W), .DEPTH(LEAD_DEPTH)) u_lead3 (
		.clk(clk), .we(we_lead3), .waddr(idx32[LAW-1:0]),
		.wdata({entry_code, entry_count[N3W-1:0]}),
		.re(ctl.rd_lead3), .raddr(i_q[LAW-1:0]), .rdata(lead3_rd)
	);

	ugil_ram #(.WIDTH(CW + NW), .DEPTH(MIDDLE_DEPTH)) u_mid3 (
		.clk(clk), .we(we_mid3), .waddr(idx32[MAW-1:0]),
		.wdata({entry_code, entry_count}),
		.re(ctl.rd_mid3), .raddr(mid_q[MAW-1:0]), .rdata(mid3_rd)
	);

	ugil_ram #(.WIDTH(CW), .DEPTH(GLYPH_DEPTH)) u_leaf2 (
		.clk(clk), .we(we_leaf2), .waddr(idx32[GAW-1:0]), .wdata(entry_code),
		.re(ctl.rd_leaf2), .raddr(skip_q[GAW-1:0]), .rdata(leaf2_rd)
	);

	ugil_ram #(.WIDTH(CW), .DEPTH(GLYPH_DEPTH)) u_leaf3 (
		.clk(clk), .we(we_leaf3), .waddr(idx32[GAW-1:0]), .wdata(entry_code),
		.re(ctl.rd_leaf3), .raddr(skip_q[GAW-1:0]), .rdata(leaf3_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n2_q <= '0;
			n3_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ugil_pkg::CFG_LEAD2_ENTRIES) begin
				n2_q <= cfg_data;
			end else begin
				n3_q <= cfg_data;
			end
		end
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			mid_q  <= '0;
			skip_q <= '0;
			c_q    <= '0;
			cnt_q  <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (ctl.capture) begin
				i_q    <= '0;
				mid_q  <= '0;
				skip_q <= '0;
				c_q    <= '0;
			end
			if (ctl.inc_i) begin
				i_q <= i_q + IW'(1);
			end
			if (ctl.ld_cnt_lead2) begin
				c_q   <= '0;
				cnt_q <= lead2_rd[NW-1:0];
			end
			if (ctl.ld_cnt_lead3) begin
				c_q   <= '0;
				cnt_q <= NW'(lead3_rd[N3W-1:0]);
			end
			if (ctl.ld_cnt_mid) begin
				c_q   <= '0;
				cnt_q <= mid3_rd[NW-1:0];
			end
			if (ctl.add_skip_lead2) begin
				skip_q <= skip_q + SKW'(lead2_rd[NW-1:0]);
			end
			if (ctl.add_skip_mid) begin
				skip_q <= skip_q + SKW'(mid3_rd[NW-1:0]);
			end
			if (ctl.inc_skip_c) begin
				skip_q <= skip_q + SKW'(1);
				c_q    <= c_q + NW'(1);
			end
			if (ctl.inc_mid_c) begin
				mid_q <= mid_q + MW'(1);
				c_q   <= c_q + NW'(1);
			end
			if (ctl.set_hit) begin
				hit_q <= lead3_rd[CW+N3W-1:N3W] == b0_q;
			end
		end
	end

	// character bytes of the current lookup
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			b0_q <= first_byte;
			b1_q <= second_byte;
			b2_q <= third_byte;
		end
	end

	// status toward the controller
	always_comb begin
		st.i_done2   = (32'(i_q) >= 32'(n2_q)) || (32'(i_q) >= 32'(LEAD_DEPTH));
		st.i_done3   = (32'(i_q) >= 32'(n3_q)) || (32'(i_q) >= 32'(LEAD_DEPTH));
		st.skip_over = 32'(skip_q) >= 32'(GLYPH_DEPTH);
		st.mid_over  = 32'(mid_q) >= 32'(MIDDLE_DEPTH);
		st.c_done    = c_q >= cnt_q;
		st.lead2_hit = lead2_rd[CW+NW-1:NW] == b0_q;
		st.leaf2_hit = leaf2_rd == b1_q;
		st.mid_hit   = hit_q && (mid3_rd[CW+NW-1:NW] == b1_q);
		st.leaf3_hit = leaf3_rd == b2_q;
		st.is_ascii  = (b0_q & ugil_pkg::ASCII_MASK) == 8'h00;
		st.is_two    = (b0_q & ugil_pkg::LEAD2_MASK) == ugil_pkg::LEAD2_VAL;
		st.is_three  = (b0_q & ugil_pkg::LEAD3_MASK) == ugil_pkg::LEAD3_VAL;
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			unique case (ctl.out_kind)
				ugil_pkg::KIND_ASCII: begin
					found          <= 1'b1;
					bytes_used     <= 2'd1;
					glyph_bank     <= ugil_pkg::BANK_ONE;
					glyph_position <= {4'd0, b0_q};
				end
				ugil_pkg::KIND_TWO: begin
					found          <= 1'b1;
					bytes_used     <= 2'd2;
					glyph_bank     <= ugil_pkg::BANK_TWO;
					glyph_position <= skip_q[ugil_pkg::POS_W-1:0];
				end
				ugil_pkg::KIND_THREE: begin
					found          <= 1'b1;
					bytes_used     <= 2'd3;
					glyph_bank     <= ugil_pkg::BANK_THREE;
					glyph_position <= skip_q[ugil_pkg::POS_W-1:0];
				end
				default: begin
					found          <= 1'b0;
					bytes_used     <= 2'd0;
					glyph_bank     <= ugil_pkg::BANK_ONE;
					glyph_position <= '0;
				end
			endcase
		end
	end

endmodule

// ===== src/ugil_ctrl.sv =====
// ugil_ctrl: state machine that sequences table scans
// depends on ugil_pkg; drives the datapath through ctl_cmd_t
module ugil_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ugil_pkg::CMD_W-1:0] cmd,
	input  logic                       out_stall,
	input  ugil_pkg::dp_status_t       st,
	output logic                       in_stall,
	output logic                       out_valid,
	output ugil_pkg::ctl_cmd_t         ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_L2_RD,
		S_L2_CHK,
		S_LF2_RD,
		S_LF2_CHK,
		S_L3_RD,
		S_L3_CHK,
		S_M_LOOP,
		S_M_CHK,
		S_LF3_RD,
		S_LF3_CHK,
		S_DONE
	} state_t;

	state_t              state_q, state_d;
	ugil_pkg::res_kind_t kind_q, kind_d;
	logic                out_valid_q;
	logic                accept;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		ctl          = '0;
		ctl.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == ugil_pkg::CMD_LOOKUP) begin
						ctl.capture = 1'b1;
						state_d     = S_DECODE;
					end else begin
						ctl.wr = 1'b1;
					end
				end
			end
			S_DECODE: begin
				if (st.is_ascii) begin
					kind_d  = ugil_pkg::KIND_ASCII;
					state_d = S_DONE;
				end else if (st.is_two) begin
					state_d = S_L2_RD;
				end else if (st.is_three) begin
					state_d = S_L3_RD;
				end else begin
					kind_d  = ugil_pkg::KIND_NONE;
					state_d = S_DONE;
				end
			end
			// two-byte lead scan
			S_L2_RD: begin
				if (st.i_done2 || st.skip_over) begin
					kind_d  = ugil_pkg::KIND_NONE;
					state_d = S_DONE;
				end else begin
					ctl.rd_lead2 = 1'b1;
					state_d      = S_L2_CHK;
				end
			end
			S_L2_CHK: begin
				if (st.lead2_hit) begin
					ctl.ld_cnt_lead2 = 1'b1;
					state_d          = S_LF2_RD;
				end else begin
					ctl.add_skip_lead2 = 1'b1;
					ctl.inc_i          = 1'b1;
					state_d            = S_L2_RD;
				end
			end
			S_LF2_RD: begin
				if (st.c_done) begin
					ctl.inc_i = 1'b1;
					state_d   = S_L2_RD;
				end else if (st.skip_over) begin
					kind_d  = ugil_pkg::KIND_NONE;
					state_d = S_DONE;
				end else begin
					ctl.rd_leaf2 = 1'b1;
					state_d      = S_LF2_CHK;
				end
			end
			S_LF2_CHK: begin
				if (st.leaf2_hit) begin
					kind_d  = ugil_pkg::KIND_TWO;
					state_d = S_DONE;
				end else begin
					ctl.inc_skip_c = 1'b1;
					state_d        = S_LF2_RD;
				end
			end
			// three-byte lead scan
			S_L3_RD: begin
				if (st.i_done3) begin
					kind_d  = ugil_pkg::KIND_NONE;
					state_d = S_DONE;
				end else begin
					ctl.rd_lead3 = 1'b1;
					state_d      = S_L3_CHK;
				end
			end
			S_L3_CHK: begin
				ctl.set_hit      = 1'b1;
				ctl.ld_cnt_lead3 = 1'b1;
				state_d          = S_M_LOOP;
			end
			S_M_LOOP: begin
				if (st.c_done) begin
					ctl.inc_i = 1'b1;
					state_d   = S_L3_RD;
				end else if (st.mid_over || st.skip_over) begin
					kind_d  = ugil_pkg::KIND_NONE;
					state_d = S_DONE;
				end else begin
					ctl.rd_mid3 = 1'b1;
					state_d     = S_M_CHK;
				end
			end
			S_M_CHK: begin
				if (st.mid_hit) begin
					ctl.ld_cnt_mid = 1'b1;
					state_d        = S_LF3_RD;
				end else begin
					ctl.add_skip_mid = 1'b1;
					ctl.inc_mid_c    = 1'b1;
					state_d          = S_M_LOOP;
				end
			end
			S_LF3_RD: begin
				if (st.c_done || st.skip_over) begin
					kind_d  = ugil_pkg::KIND_NONE;
					state_d = S_DONE;
				end else begin
					ctl.rd_leaf3 = 1'b1;
					state_d      = S_LF3_CHK;
				end
			end
			S_LF3_CHK: begin
				if (st.leaf3_hit) begin
					kind_d  = ugil_pkg::KIND_THREE;
					state_d = S_DONE;
				end else begin
					ctl.inc_skip_c = 1'b1;
					state_d        = S_LF3_RD;
				end
			end
			// hand the result to the output register once it is free
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= ugil_pkg::KIND_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/ugil_checker.sv =====
// ugil_checker: port level assertions for utf8_glyph_index_lookup_top
// depends on ugil_pkg; bound to the top level below
module ugil_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         found,
	input logic [1:0]                   bytes_used,
	input logic [1:0]                   glyph_bank,
	input logic [ugil_pkg::POS_W-1:0]   glyph_position
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(glyph_position))
		else $error("stalled result beat changed");

	// a miss carries all zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> bytes_used == 2'd0 && glyph_bank == ugil_pkg::BANK_ONE
			&& glyph_position == '0)
		else $error("miss with nonzero fields");

	// byte count follows the bank
	a_bytes_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> bytes_used == glyph_bank + 2'd1)
		else $error("bytes used does not match bank");

	// one-byte glyphs stay below 128
	a_ascii_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found && glyph_bank == ugil_pkg::BANK_ONE
			|-> glyph_position[ugil_pkg::POS_W-1:7] == '0)
		else $error("one-byte glyph out of range");

endmodule

bind utf8_glyph_index_lookup_top ugil_checker u_ugil_checker (.*);

// ===== verif/tb_utf8_glyph_index_lookup_top.sv =====
// testbench for utf8_glyph_index_lookup_top: loads the tables, then runs directed
// and random lookup, table write and register traffic against a local glyph predictor
// depends on ugil_pkg and the top level only
module tb_utf8_glyph_index_lookup_top;

	localparam int CYCLE_LIMIT  = 50000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LEAD_DEPTH   = ugil_pkg::LEAD_DEPTH;
	localparam int MIDDLE_DEPTH = ugil_pkg::MIDDLE_DEPTH;
	localparam int GLYPH_DEPTH  = ugil_pkg::GLYPH_DEPTH;
	localparam int LEAF_FILL    = 128;
	localparam int RANDOM_ITEMS = 330;
	localparam int POS_W        = ugil_pkg::POS_W;

	// command codes the block ignores
	localparam logic [ugil_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [ugil_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ugil_pkg::CMD_W-1:0] cmd;
	logic [ugil_pkg::INDEX_W-1:0] entry_index;
	logic [ugil_pkg::CODE_W-1:0] entry_code;
	logic [ugil_pkg::COUNT_W-1:0] entry_count;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;
	logic out_valid;
	logic out_stall;
	logic found;
	logic [1:0] bytes_used;
	logic [1:0] glyph_bank;
	logic [POS_W-1:0] glyph_position;
	logic cfg_we;
	logic cfg_index;
	logic [ugil_pkg::NLEAD_W-1:0] cfg_data;

	utf8_glyph_index_lookup_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .entry_index(entry_index), .entry_code(entry_code),
		.entry_count(entry_count), .first_byte(first_byte),
		.second_byte(second_byte), .third_byte(third_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .bytes_used(bytes_used), .glyph_bank(glyph_bank),
		.glyph_position(glyph_position),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct packed {
		logic found;
		logic [1:0] used;
		logic [1:0] bank;
		logic [POS_W-1:0] pos;
	} glyph_t;

	// shadow copy of the font tables and entry counts
	logic [7:0] sh_lead2_code [LEAD_DEPTH];
	int sh_lead2_cnt [LEAD_DEPTH];
	logic [7:0] sh_lead3_code [LEAD_DEPTH];
	int sh_lead3_cnt [LEAD_DEPTH];
	logic [7:0] sh_mid_code [MIDDLE_DEPTH];
	int sh_mid_cnt [MIDDLE_DEPTH];
	logic [7:0] sh_leaf2 [GLYPH_DEPTH];
	logic [7:0] sh_leaf3 [GLYPH_DEPTH];
	bit sh_leaf2_ok [GLYPH_DEPTH];
	bit sh_leaf3_ok [GLYPH_DEPTH];
	int sh_nlead2;
	int sh_nlead3;

	glyph_t pending_glyphs [$];
	int errors;
	int lookups_sent;
	int lookups_moved;
	int glyphs_seen;
	int hits_seen;
	int cycles;
	logic took;
	bit touched_unwritten;
	int burst_left;
	int stall_mode;

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int clamp_leads(int n);
		return (n > LEAD_DEPTH) ? LEAD_DEPTH : n;
	endfunction

	// two-byte scan over lead entries and their leaf runs
	function automatic bit scan_two(logic [7:0] b0, logic [7:0] b1, output int pos);
		int skip;
		int n;
		skip = 0;
		pos = 0;
		n = clamp_leads(sh_nlead2);
		for (int i = 0; i < n; i++) begin
			if (sh_lead2_code[i] == b0) begin
				for (int c = 0; c < sh_lead2_cnt[i]; c++) begin
					if (skip >= GLYPH_DEPTH) return 0;
					if (!sh_leaf2_ok[skip]) touched_unwritten = 1;
					if (sh_leaf2[skip] == b1) begin
						pos = skip;
						return 1;
					end
					skip++;
				end
			end else begin
				skip += sh_lead2_cnt[i];
			end
			if (skip >= GLYPH_DEPTH) return 0;
		end
		return 0;
	endfunction

	// three-byte scan: lead, middle run, leaf run
	function automatic bit scan_three(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			output int pos);
		int skip;
		int mid;
		int n;
		bit hit;
		skip = 0;
		mid = 0;
		pos = 0;
		n = clamp_leads(sh_nlead3);
		for (int i = 0; i < n; i++) begin
			hit = (sh_lead3_code[i] == b0);
			for (int c = 0; c < sh_lead3_cnt[i]; c++) begin
				if (mid >= MIDDLE_DEPTH || skip >= GLYPH_DEPTH) return 0;
				if (hit && sh_mid_code[mid] == b1) begin
					for (int k = 0; k < sh_mid_cnt[mid]; k++) begin
						if (skip >= GLYPH_DEPTH) return 0;
						if (!sh_leaf3_ok[skip]) touched_unwritten = 1;
						if (sh_leaf3[skip] == b2) begin
							pos = skip;
							return 1;
						end
						skip++;
					end
					return 0;
				end
				skip += sh_mid_cnt[mid];
				mid++;
			end
		end
		return 0;
	endfunction

	function automatic glyph_t predict_glyph(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		glyph_t g;
		int p;
		g = '0;
		if ((b0 & ugil_pkg::ASCII_MASK) == 8'h00) begin
			g.found = 1;
			g.used = 2'd1;
			g.bank = ugil_pkg::BANK_ONE;
			g.pos = POS_W'(b0);
		end else if ((b0 & ugil_pkg::LEAD2_MASK) == ugil_pkg::LEAD2_VAL) begin
			if (scan_two(b0, b1, p)) begin
				g.found = 1;
				g.used = 2'd2;
				g.bank = ugil_pkg::BANK_TWO;
				g.pos = POS_W'(p);
			end
		end else if ((b0 & ugil_pkg::LEAD3_MASK) == ugil_pkg::LEAD3_VAL) begin
			if (scan_three(b0, b1, b2, p)) begin
				g.found = 1;
				g.used = 2'd3;
				g.bank = ugil_pkg::BANK_THREE;
				g.pos = POS_W'(p);
			end
		end
		return g;
	endfunction

	// input monitor: update shadow state and queue expected glyphs per accepted beat
	always @(posedge clk) begin
		took <= in_valid && !in_stall;
		if (arst_n && cfg_we) begin
			if (cfg_index == ugil_pkg::CFG_LEAD2_ENTRIES) sh_nlead2 = int'(cfg_data);
			else sh_nlead3 = int'(cfg_data);
		end
		if (arst_n && in_valid && !in_stall) begin
			case (cmd)
				ugil_pkg::CMD_WR_LEAD2: if (entry_index < LEAD_DEPTH) begin
					sh_lead2_code[entry_index] = entry_code;
					sh_lead2_cnt[entry_index] = int'(entry_count);
				end
				ugil_pkg::CMD_WR_LEAD3: if (entry_index < LEAD_DEPTH) begin
					sh_lead3_code[entry_index] = entry_code;
					sh_lead3_cnt[entry_index] =
						int'(entry_count[ugil_pkg::LEAD3_COUNT_W-1:0]);
				end
				ugil_pkg::CMD_WR_MID3: if (entry_index < MIDDLE_DEPTH) begin
					sh_mid_code[entry_index] = entry_code;
					sh_mid_cnt[entry_index] = int'(entry_count);
				end
				ugil_pkg::CMD_WR_LEAF2: if (entry_index < GLYPH_DEPTH) begin
					sh_leaf2[entry_index] = entry_code;
					sh_leaf2_ok[entry_index] = 1;
				end
				ugil_pkg::CMD_WR_LEAF3: if (entry_index < GLYPH_DEPTH) begin
					sh_leaf3[entry_index] = entry_code;
					sh_leaf3_ok[entry_index] = 1;
				end
				ugil_pkg::CMD_LOOKUP: pending_glyphs.push_back(
					predict_glyph(first_byte, second_byte, third_byte));
				default: ;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		glyph_t e;
		if (arst_n && out_valid && !out_stall) begin
			glyphs_seen++;
			if (found) hits_seen++;
			if (pending_glyphs.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, found=%0d pos=%0d",
					$time, found, glyph_position);
			end else begin
				e = pending_glyphs.pop_front();
				if (found !== e.found || bytes_used !== e.used || glyph_bank !== e.bank
						|| glyph_position !== e.pos) begin
					errors++;
					$display("%0t: mismatch exp f=%0d u=%0d b=%0d p=%0d got f=%0d u=%0d b=%0d p=%0d",
						$time, e.found, e.used, e.bank, e.pos,
						found, bytes_used, glyph_bank, glyph_position);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results pending",
				$time, pending_glyphs.size());
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stall pattern: switches between random stall modes
	initial begin
		int left;
		out_stall = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				stall_mode = $urandom_range(0, 3);
				left = $urandom_range(5, 60);
			end
			left--;
			case (stall_mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 1) == 0);
				default: out_stall = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// send one beat; called at a falling edge, returns at a falling edge
	task automatic send_beat(logic [ugil_pkg::CMD_W-1:0] c, logic [ugil_pkg::INDEX_W-1:0] idx,
			logic [ugil_pkg::CODE_W-1:0] code, logic [ugil_pkg::COUNT_W-1:0] cnt,
			logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid = 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd = c;
		entry_index = idx;
		entry_code = code;
		entry_count = cnt;
		first_byte = b0;
		second_byte = b1;
		third_byte = b2;
		in_valid = 1;
		if (c == ugil_pkg::CMD_LOOKUP) lookups_sent++;
		do @(negedge clk); while (!took);
	endtask

	// a lookup that would read a leaf never written becomes a one-byte lookup
	task automatic lookup(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		touched_unwritten = 0;
		void'(predict_glyph(b0, b1, b2));
		if (touched_unwritten) begin
			b0 = b0 & ~ugil_pkg::ASCII_MASK;
			lookups_moved++;
		end
		send_beat(ugil_pkg::CMD_LOOKUP, ugil_pkg::INDEX_W'($urandom),
			ugil_pkg::CODE_W'($urandom), ugil_pkg::COUNT_W'($urandom), b0, b1, b2);
	endtask

	task automatic write_entry(logic [ugil_pkg::CMD_W-1:0] c, int idx, int code, int cnt);
		send_beat(c, ugil_pkg::INDEX_W'(idx), ugil_pkg::CODE_W'(code),
			ugil_pkg::COUNT_W'(cnt), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// wait for the block to settle, then write a register
	task automatic set_entries(logic which, int n);
		in_valid = 0;
		while (pending_glyphs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1;
		cfg_index = which;
		cfg_data = ugil_pkg::NLEAD_W'(n);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// small code alphabets so lookups hit often
	function automatic logic [7:0] lead2_pick();
		return 8'(8'hC0 + $urandom_range(0, 3));
	endfunction
	function automatic logic [7:0] lead3_pick();
		return 8'(8'hE0 + $urandom_range(0, 2));
	endfunction
	function automatic logic [7:0] tail_pick();
		return 8'(8'h80 + $urandom_range(0, 7));
	endfunction

	// with no leads configured only one-byte characters are found
	task automatic test_no_leads();
		lookup(8'h41, 8'h00, 8'h00);
		lookup(8'hC0, 8'h80, 8'h00);
	endtask

	// write every lead and middle entry and the front of both leaf tables
	task automatic test_fill_tables();
		for (int i = 0; i < LEAD_DEPTH; i++)
			write_entry(ugil_pkg::CMD_WR_LEAD2, i, int'(lead2_pick()), $urandom_range(0, 3));
		for (int i = 0; i < LEAD_DEPTH; i++)
			write_entry(ugil_pkg::CMD_WR_LEAD3, i, int'(lead3_pick()), $urandom_range(0, 3));
		for (int i = 0; i < MIDDLE_DEPTH; i++)
			write_entry(ugil_pkg::CMD_WR_MID3, i, int'(tail_pick()), $urandom_range(0, 3));
		for (int i = 0; i < LEAF_FILL; i++)
			write_entry(ugil_pkg::CMD_WR_LEAF2, i, int'(tail_pick()), 0);
		for (int i = 0; i < LEAF_FILL; i++)
			write_entry(ugil_pkg::CMD_WR_LEAF3, i, int'(tail_pick()), 0);
	endtask

	// one-byte, four-byte and invalid leads, unused commands, ignored writes
	task automatic test_directed_leads();
		set_entries(ugil_pkg::CFG_LEAD2_ENTRIES, 8);
		set_entries(ugil_pkg::CFG_LEAD3_ENTRIES, 8);
		lookup(8'h00, 8'h00, 8'h00);
		lookup(8'h7F, 8'hFF, 8'hFF);
		lookup(8'h80, 8'h80, 8'h80);
		lookup(8'hF0, 8'h90, 8'h80);
		lookup(8'hFF, 8'hFF, 8'hFF);
		lookup(8'hC0, 8'h80, 8'h80);
		lookup(8'hE0, 8'h80, 8'h80);
		send_beat(CMD_SPARE_A, 12'hFFF, 8'hFF, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
		send_beat(CMD_SPARE_B, 12'h000, 8'h00, 13'h0000, 8'h00, 8'h00, 8'h00);
		// index past the end of the lead and middle tables is dropped
		write_entry(ugil_pkg::CMD_WR_LEAD2, 12'hFFF, 8'hC1, 1);
		write_entry(ugil_pkg::CMD_WR_LEAD3, LEAD_DEPTH, 8'hE1, 1);
		write_entry(ugil_pkg::CMD_WR_MID3, MIDDLE_DEPTH, 8'h81, 1);
		lookup(8'hC1, 8'h81, 8'h80);
		lookup(8'hE1, 8'h81, 8'h82);
	endtask

	// long runs: skips past the glyph table end and 9-bit lead3 counts
	task automatic test_directed_runs();
		set_entries(ugil_pkg::CFG_LEAD2_ENTRIES, 64);
		write_entry(ugil_pkg::CMD_WR_LEAD2, 0, 8'hDF, 13'h1000);
		lookup(8'hDF, 8'h80, 8'h00);
		lookup(8'hC2, 8'h80, 8'h00);
		write_entry(ugil_pkg::CMD_WR_LEAD2, 0, 8'hC3, 2);
		set_entries(ugil_pkg::CFG_LEAD3_ENTRIES, 64);
		write_entry(ugil_pkg::CMD_WR_LEAD3, 0, 8'hEF, 13'h1FFF);
		lookup(8'hEF, 8'hBF, 8'hBF);
		lookup(8'hEF, 8'h80, 8'h81);
		write_entry(ugil_pkg::CMD_WR_LEAD3, 0, 8'hE0, 2);
		// lead counts above the table depth are treated as the depth
		set_entries(ugil_pkg::CFG_LEAD2_ENTRIES, 127);
		set_entries(ugil_pkg::CFG_LEAD3_ENTRIES, 127);
		lookup(8'hC1, 8'h83, 8'h00);
		lookup(8'hE2, 8'h84, 8'h85);
		set_entries(ugil_pkg::CFG_LEAD2_ENTRIES, 0);
		set_entries(ugil_pkg::CFG_LEAD3_ENTRIES, 0);
		lookup(8'hC0, 8'h80, 8'h00);
		lookup(8'hE0, 8'h80, 8'h80);
	endtask

	function automatic int count_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 97) return $urandom_range(0, 3);
		return $urandom_range(0, 8191);
	endfunction

	function automatic int code_pick(logic [7:0] usual);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : int'(usual);
	endfunction

	// random mix: mostly well-formed lookups and table edits, some noise
	task automatic test_random_traffic();
		int r;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				set_entries(ugil_pkg::CFG_LEAD2_ENTRIES, ($urandom_range(0, 4) == 0) ?
					$urandom_range(0, 127) : $urandom_range(1, 40));
				set_entries(ugil_pkg::CFG_LEAD3_ENTRIES, ($urandom_range(0, 4) == 0) ?
					$urandom_range(0, 127) : $urandom_range(1, 40));
			end
			r = $urandom_range(0, 99);
			if (r < 25)
				lookup(lead2_pick(), tail_pick(), 8'($urandom));
			else if (r < 50)
				lookup(lead3_pick(), tail_pick(), tail_pick());
			else if (r < 60)
				lookup(8'($urandom), 8'($urandom), 8'($urandom));
			else if (r < 66)
				write_entry(ugil_pkg::CMD_WR_LEAD2, $urandom_range(0, 4095),
					code_pick(lead2_pick()), count_pick());
			else if (r < 72)
				write_entry(ugil_pkg::CMD_WR_LEAD3, $urandom_range(0, 127),
					code_pick(lead3_pick()),
					($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) :
					$urandom_range(0, 3));
			else if (r < 80)
				write_entry(ugil_pkg::CMD_WR_MID3, $urandom_range(0, 511),
					code_pick(tail_pick()), count_pick());
			else if (r < 88)
				write_entry(ugil_pkg::CMD_WR_LEAF2, $urandom_range(0, 4095),
					code_pick(tail_pick()), 0);
			else if (r < 96)
				write_entry(ugil_pkg::CMD_WR_LEAF3, $urandom_range(0, 4095),
					code_pick(tail_pick()), 0);
			else
				send_beat(($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B,
					ugil_pkg::INDEX_W'($urandom), ugil_pkg::CODE_W'($urandom),
					ugil_pkg::COUNT_W'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
		end
	endtask

	initial begin
		errors = 0;
		lookups_sent = 0;
		lookups_moved = 0;
		glyphs_seen = 0;
		hits_seen = 0;
		cycles = 0;
		burst_left = 0;
		took = 0;
		touched_unwritten = 0;
		sh_nlead2 = 0;
		sh_nlead3 = 0;
		arst_n = 0;
		in_valid = 0;
		cmd = ugil_pkg::CMD_LOOKUP;
		entry_index = '0;
		entry_code = '0;
		entry_count = '0;
		first_byte = '0;
		second_byte = '0;
		third_byte = '0;
		cfg_we = 0;
		cfg_index = ugil_pkg::CFG_LEAD2_ENTRIES;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		test_no_leads();
		test_fill_tables();
		test_directed_leads();
		test_directed_runs();
		test_random_traffic();

		in_valid = 0;
		while (pending_glyphs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d lookups (%0d results, %0d glyphs found, %0d folded to one byte)",
			lookups_sent, glyphs_seen, hits_seen, lookups_moved);
		$display("plus table loads, register settings 0 to 127, ignored commands; %0d errors",
			errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
